### sv/mird_pkg.sv
// Shared types, constants and the CRC step for the Modbus IMU response deframer.
`timescale 1ns / 1ps
package mird_pkg;

  // Payload store geometry: two banks of one frame's payload each
  localparam int PAYLOAD_BYTES = 30;
  localparam int PL_AW         = $clog2(PAYLOAD_BYTES);
  localparam int RAM_AW        = PL_AW + 1;

  // Frame constants
  localparam logic [7:0]  DEV_ADDR_RST = 8'h50;
  localparam logic [7:0]  FC_READ_HOLD = 8'h03;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [8:0]  POS_MAX      = 9'd511;
  localparam logic [8:0]  HDR_BYTES    = 9'd3;
  localparam logic [8:0]  MIN_FRAME    = 9'd5;

  // Byte counts that select a block
  localparam logic [7:0] CNT_MAIN = 8'd30;
  localparam logic [7:0] CNT_QUAT = 8'd8;
  localparam logic [7:0] CNT_TEMP = 8'd2;

  // Value indexes within the blocks
  localparam logic [3:0] MAIN_I16_VALUES = 4'd9;
  localparam logic [3:0] MAIN_LAST_IDX   = 4'd11;
  localparam logic [3:0] QUAT_LAST_IDX   = 4'd3;

  typedef enum logic [1:0] {
    KIND_MAIN = 2'd0,
    KIND_QUAT = 2'd1,
    KIND_TEMP = 2'd2
  } kind_e;

  // One accepted frame waiting to be unpacked
  typedef struct packed {
    logic  bank;
    kind_e kind;
  } job_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
    job_t head;
  } q_stat_t;

  // Payload store write request
  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  // One byte of CRC-16/Modbus, reflected polynomial
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/modbus_imu_response_deframer_core.sv
// Top level of the Modbus RTU holding-register response deframer.
//
// Input stream: one frame byte per item on s_axis_tdata, s_axis_tlast on the
// last byte of a frame. Output stream: one decoded register value per item,
// block kind on m_axis_tuser, last value of the frame on m_axis_tlast.
// cfg_we_i/cfg_wdata_i load the expected slave address (0x50 after reset).
// Bytes are taken one per cycle. A frame that passes the address, function,
// length and CRC checks is queued; the payload sits in one of two RAM banks.
// The input stalls only when two accepted frames are still being unpacked.
// The unpacker reads the payload from the RAM port byte by byte, a read
// state then a capture state per byte; an int16 value takes two bytes and
// an int32 value four, and each value then passes a put state.
// The output register holds its item while m_axis_tready is low, and the
// unpacker then waits with the next value ready. Reset clears all frame
// state and the queue; the payload RAM is not cleared.
`timescale 1ns / 1ps
module modbus_imu_response_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] value_index, [35:4] raw_value, [39:36] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] block_kind
  output logic        m_axis_tlast
);

  mird_pkg::q_stat_t          q_stat;
  mird_pkg::job_t             job;
  mird_pkg::ram_wr_t          ram_wr;
  logic                       push;
  logic                       pop;
  logic                       rd_en;
  logic [mird_pkg::RAM_AW-1:0] rd_addr;
  logic [7:0]                 rd_data;
  mird_pkg::kind_e            out_kind;
  logic [3:0]                 out_idx;
  logic signed [31:0]         out_value;

  mird_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .rx_byte_i   (s_axis_tdata),
    .frame_end_i (s_axis_tlast),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .job_o       (job),
    .ram_wr_o    (ram_wr)
  );

  mird_ram #(
    .DW (8),
    .AW (mird_pkg::RAM_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  mird_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .stat_o (q_stat)
  );

  mird_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_idx_o   (out_idx),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast)
  );

  // Output packing
  assign m_axis_tdata = {4'b0000, out_value, out_idx};
  assign m_axis_tuser = out_kind;

endmodule

### sv/mird_ram.sv
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module mird_ram #(
  parameter int DW = 8,
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/mird_front.sv
// Front end: frame parsing, CRC, payload capture and frame acceptance.
`timescale 1ns / 1ps
module mird_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_end_i,
  input  mird_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output mird_pkg::job_t      job_o,
  output mird_pkg::ram_wr_t   ram_wr_o
);

  logic [7:0]  dev_addr_q;
  logic [8:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic        hdr_ok_q, hdr_ok_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic        bank_q;

  logic        accept;
  logic [8:0]  limit;
  logic [8:0]  pay_idx;
  logic        frame_ok;
  logic        kind_ok;
  mird_pkg::kind_e kind;

  // A byte may enter only while a payload bank is free
  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // Per-byte frame parsing
  always_comb begin
    hdr_ok_d = hdr_ok_q;
    count_d  = count_q;
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    ram_wr_o.we   = 1'b0;
    ram_wr_o.data = rx_byte_i;

    if (pos_q == 9'd0) begin
      hdr_ok_d = (rx_byte_i == dev_addr_q);
    end else if (pos_q == 9'd1) begin
      hdr_ok_d = hdr_ok_q && (rx_byte_i == mird_pkg::FC_READ_HOLD);
    end else if (pos_q == 9'd2) begin
      count_d = rx_byte_i;
    end

    limit   = mird_pkg::HDR_BYTES + {1'b0, count_d};
    pay_idx = pos_q - mird_pkg::HDR_BYTES;
    ram_wr_o.addr = {bank_q, pay_idx[mird_pkg::PL_AW-1:0]};

    if (pos_q < mird_pkg::HDR_BYTES || pos_q < limit) begin
      crc_d = mird_pkg::crc_byte(crc_q, rx_byte_i);
      if (pos_q >= mird_pkg::HDR_BYTES && pay_idx < 9'(mird_pkg::PAYLOAD_BYTES)) begin
        ram_wr_o.we = accept;
      end
    end else if (pos_q == limit) begin
      rx_crc_d[7:0] = rx_byte_i;
    end else if (pos_q == limit + 9'd1) begin
      rx_crc_d[15:8] = rx_byte_i;
    end

    pos_d = (pos_q == mird_pkg::POS_MAX) ? pos_q : pos_q + 9'd1;

    frame_ok = (pos_d >= mird_pkg::MIN_FRAME) && hdr_ok_d &&
               (pos_d >= {1'b0, count_d} + mird_pkg::MIN_FRAME) && (rx_crc_d == crc_d);
  end

  // Block kind from the byte count
  always_comb begin
    kind    = mird_pkg::KIND_MAIN;
    kind_ok = 1'b1;
    case (count_d)
      mird_pkg::CNT_MAIN: kind = mird_pkg::KIND_MAIN;
      mird_pkg::CNT_QUAT: kind = mird_pkg::KIND_QUAT;
      mird_pkg::CNT_TEMP: kind = mird_pkg::KIND_TEMP;
      default:            kind_ok = 1'b0;
    endcase
  end

  assign push_o     = accept && frame_end_i && frame_ok && kind_ok;
  assign job_o.bank = bank_q;
  assign job_o.kind = kind;

  // Frame state; cleared after every frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= mird_pkg::DEV_ADDR_RST;
      pos_q      <= 9'd0;
      crc_q      <= mird_pkg::CRC_INIT;
      hdr_ok_q   <= 1'b0;
      count_q    <= 8'd0;
      rx_crc_q   <= 16'd0;
      bank_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      if (push_o) begin
        bank_q <= !bank_q;
      end
      if (accept) begin
        if (frame_end_i) begin
          pos_q    <= 9'd0;
          crc_q    <= mird_pkg::CRC_INIT;
          hdr_ok_q <= 1'b0;
          count_q  <= 8'd0;
          rx_crc_q <= 16'd0;
        end else begin
          pos_q    <= pos_d;
          crc_q    <= crc_d;
          hdr_ok_q <= hdr_ok_d;
          count_q  <= count_d;
          rx_crc_q <= rx_crc_d;
        end
      end
    end
  end

endmodule

### sv/mird_queue.sv
// Two-entry queue of accepted frames between front and back.
`timescale 1ns / 1ps
module mird_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mird_pkg::job_t    job_i,
  input  logic              pop_i,
  output mird_pkg::q_stat_t stat_o
);

  mird_pkg::job_t ent_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign stat_o.head  = ent_q[rd_ptr_q];

  // Entries hold job data only and are not reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### sv/mird_back.sv
// Back end: reads a stored payload byte by byte and emits the decoded values.
`timescale 1ns / 1ps
module mird_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mird_pkg::q_stat_t           q_stat_i,
  output logic                        pop_o,
  output logic                        rd_en_o,
  output logic [mird_pkg::RAM_AW-1:0] rd_addr_o,
  input  logic [7:0]                  rd_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mird_pkg::kind_e             out_kind_o,
  output logic [3:0]                  out_idx_o,
  output logic signed [31:0]          out_value_o,
  output logic                        out_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CAP,
    ST_PUT
  } state_e;

  state_e                     state_q;
  logic [mird_pkg::PL_AW-1:0] byte_q;
  logic [3:0]                 val_q;
  logic [1:0]                 sub_q;
  logic [31:0]                acc_q;

  logic        wide;
  logic [1:0]  sub_last;
  logic        is_last;
  logic        slot_free;
  logic [31:0] value;

  // Value shape for the current index
  always_comb begin
    wide     = (q_stat_i.head.kind == mird_pkg::KIND_MAIN) && (val_q >= mird_pkg::MAIN_I16_VALUES);
    sub_last = wide ? 2'd3 : 2'd1;
    // int32 is two big-endian words, low word first
    value    = wide ? {acc_q[15:0], acc_q[31:16]} : {{16{acc_q[15]}}, acc_q[15:0]};
    case (q_stat_i.head.kind)
      mird_pkg::KIND_MAIN: is_last = (val_q == mird_pkg::MAIN_LAST_IDX);
      mird_pkg::KIND_QUAT: is_last = (val_q == mird_pkg::QUAT_LAST_IDX);
      mird_pkg::KIND_TEMP: is_last = 1'b1;
      default:             is_last = 1'b1;
    endcase
  end

  assign slot_free = !out_valid_o || out_ready_i;
  assign pop_o     = (state_q == ST_PUT) && slot_free && is_last;
  assign rd_en_o   = (state_q == ST_READ);
  assign rd_addr_o = {q_stat_i.head.bank, byte_q};

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      byte_q      <= '0;
      val_q       <= 4'd0;
      sub_q       <= 2'd0;
      acc_q       <= 32'd0;
      out_valid_o <= 1'b0;
      out_kind_o  <= mird_pkg::KIND_MAIN;
      out_idx_o   <= 4'd0;
      out_value_o <= 32'sd0;
      out_last_o  <= 1'b0;
    end else begin
      // Output register: loaded by the sequencer, emptied when taken
      if (state_q == ST_PUT && slot_free) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_stat_i.valid) begin
            byte_q  <= '0;
            val_q   <= 4'd0;
            sub_q   <= 2'd0;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_CAP;
        end
        ST_CAP: begin
          acc_q  <= {acc_q[23:0], rd_data_i};
          byte_q <= byte_q + 1'b1;
          if (sub_q == sub_last) begin
            sub_q   <= 2'd0;
            state_q <= ST_PUT;
          end else begin
            sub_q   <= sub_q + 2'd1;
            state_q <= ST_READ;
          end
        end
        ST_PUT: begin
          if (slot_free) begin
            out_kind_o  <= q_stat_i.head.kind;
            out_idx_o   <= val_q;
            out_value_o <= value;
            out_last_o  <= is_last;
            val_q       <= val_q + 4'd1;
            state_q     <= is_last ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/mird_checker.sv
// Port-level checks on the deframer output stream, bound to the top level.
`timescale 1ns / 1ps
module mird_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Only three block kinds exist
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("bad block kind");

  // Index range and zero padding
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd11 && m_axis_tdata[39:36] == 4'd0)
    else $error("value index out of range");

  // Temperature block is a single value
  a_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == 2'd2 |-> m_axis_tlast && m_axis_tdata[3:0] == 4'd0)
    else $error("temperature block malformed");

  // Last mark sits on the final index of quaternion and main blocks
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 2'd2 |->
      m_axis_tlast == ((m_axis_tuser == 2'd1 && m_axis_tdata[3:0] == 4'd3) ||
                       (m_axis_tuser == 2'd0 && m_axis_tdata[3:0] == 4'd11)))
    else $error("last mark misplaced");

endmodule

bind modbus_imu_response_deframer_core mird_checker u_mird_checker (.*);
